/* rtl/lpsc_pkg.sv */
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package lpsc_pkg;

	localparam int BYTES_LEFT_W   = 24;
	localparam int LENGTH_W       = 32;
	localparam int HDR_ACC_W      = 24;
	localparam int START_CODE_LEN = 4;
	localparam int Q_DEPTH        = 8;
	localparam int Q_AW           = 3;

	localparam logic [1:0] SC_LAST_IDX  = 2'(START_CODE_LEN - 1);
	localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
	localparam logic [7:0] SC_ONE_BYTE  = 8'h01;

	// one queued unit of work: a whole start code or one payload byte
	typedef struct packed {
		logic       is_start;
		logic [7:0] data;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_port_t;

endpackage

/* rtl/lpsc_front.sv */
// ----------------------------------------------------------------------------
// lpsc_front
// Accepts sample bytes, tracks header / payload / discard and queues work.
// ----------------------------------------------------------------------------
module lpsc_front #(
	parameter int SAMPLE_LEN_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [31:0]            s_axis_tdata,  // [7:0] data_byte, [31:8] bytes_left
	input  logic                   q_full,
	output lpsc_pkg::q_port_t      push
);

	localparam int LEFT_W = (SAMPLE_LEN_BITS < lpsc_pkg::BYTES_LEFT_W) ?
		SAMPLE_LEN_BITS : lpsc_pkg::BYTES_LEFT_W;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	phase_t                             phase_q, phase_d;
	logic [1:0]                         hcnt_q, hcnt_d;
	logic [lpsc_pkg::HDR_ACC_W-1:0]     acc_q, acc_d;
	logic [LEFT_W-1:0]                  pleft_q, pleft_d;

	logic                               accept;
	logic [7:0]                         data_byte;
	logic [LEFT_W-1:0]                  left_w;
	logic                               is_last;
	logic [LEFT_W-1:0]                  after;
	logic [lpsc_pkg::LENGTH_W-1:0]      acc_n;
	logic                               fits;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign data_byte     = s_axis_tdata[7:0];
	assign left_w        = s_axis_tdata[8 +: LEFT_W];
	assign is_last       = (left_w <= LEFT_W'(1));
	assign after         = is_last ? '0 : left_w - LEFT_W'(1);
	assign acc_n         = {acc_q, data_byte};
	assign fits          = (acc_n <= lpsc_pkg::LENGTH_W'(after));

	always_comb begin
		phase_d    = phase_q;
		hcnt_d     = hcnt_q;
		acc_d      = acc_q;
		pleft_d    = pleft_q;
		push.valid = 1'b0;
		push.entry = '{is_start: 1'b0, data: data_byte};
		unique case (phase_q)
			PH_HEADER: begin
				if (hcnt_q == lpsc_pkg::SC_LAST_IDX) begin
					hcnt_d = '0;
					acc_d  = '0;
					if (fits) begin
						push.valid          = accept;
						push.entry.is_start = 1'b1;
						pleft_d             = acc_n[LEFT_W-1:0];
						phase_d = (acc_n[LEFT_W-1:0] != '0) ? PH_PAYLOAD : PH_HEADER;
					end else begin
						phase_d = PH_DISCARD;
					end
				end else begin
					hcnt_d = hcnt_q + 2'd1;
					acc_d  = acc_n[lpsc_pkg::HDR_ACC_W-1:0];
				end
			end
			PH_PAYLOAD: begin
				push.valid = accept;
				pleft_d    = pleft_q - LEFT_W'(1);
				if (pleft_d == '0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		// end of sample always restarts header collection
		if (is_last) begin
			phase_d = PH_HEADER;
			hcnt_d  = '0;
			acc_d   = '0;
			pleft_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcnt_q  <= '0;
			acc_q   <= '0;
			pleft_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			acc_q   <= acc_d;
			pleft_q <= pleft_d;
		end
	end

endmodule

/* rtl/lpsc_queue.sv */
// ----------------------------------------------------------------------------
// lpsc_queue
// Short work queue between the front and the back.
// ----------------------------------------------------------------------------
module lpsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  lpsc_pkg::q_port_t  push,
	input  logic               pop,
	output logic               full,
	output lpsc_pkg::q_port_t  head
);

	lpsc_pkg::q_entry_t              mem_q [lpsc_pkg::Q_DEPTH];
	logic [lpsc_pkg::Q_AW-1:0]       wr_q;
	logic [lpsc_pkg::Q_AW-1:0]       rd_q;
	logic [lpsc_pkg::Q_AW:0]         count_q;
	logic                            do_pop;

	assign full       = (count_q == (lpsc_pkg::Q_AW + 1)'(lpsc_pkg::Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/lpsc_back.sv */
// ----------------------------------------------------------------------------
// lpsc_back
// Expands queued work into output bytes behind a registered output stage.
// ----------------------------------------------------------------------------
module lpsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lpsc_pkg::q_port_t  head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [7:0]         m_axis_tdata,  // [7:0] out_byte
	output logic               m_axis_tuser,  // [0] unit_start
	output logic               m_axis_tlast
);

	logic        valid_q;
	logic [7:0]  data_q;
	logic        start_q;
	logic        last_q;
	logic [1:0]  idx_q;
	logic        load;
	logic        sc_end;

	assign load   = !valid_q || m_axis_tready;
	assign sc_end = (idx_q == lpsc_pkg::SC_LAST_IDX);
	assign pop    = load && head.valid && (!head.entry.is_start || sc_end);

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = start_q;
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid && head.entry.is_start) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			if (head.entry.is_start) begin
				data_q  <= sc_end ? lpsc_pkg::SC_ONE_BYTE : lpsc_pkg::SC_ZERO_BYTE;
				start_q <= (idx_q == '0);
				last_q  <= sc_end;
			end else begin
				data_q  <= head.entry.data;
				start_q <= 1'b0;
				last_q  <= 1'b1;
			end
		end
	end

endmodule

/* rtl/length_prefix_to_start_code.sv */
// ----------------------------------------------------------------------------
// length_prefix_to_start_code
// Turns length-prefixed units of a sample into start-code delimited units.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser        tlast
//  s_axis    in   [7:0] data_byte [31:8] left    -            -
//  m_axis    out  [7:0] out_byte                 unit_start   run_last
//
//  one input byte per cycle unless the queue is full; the front updates its
//  state on accept; work goes through the queue into the output register
//  a fourth header byte with a fitting length queues one start-code job, which
//  the back plays as four beats, one per cycle unless stalled: bytes match beats
//  an 8-entry queue sits between front and back; s_axis_tready drops when full
//  arst_n clears the phase, header count, length, queue and output register
// ----------------------------------------------------------------------------
module length_prefix_to_start_code #(
	parameter int SAMPLE_LEN_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [7:0] data_byte, [31:8] bytes_left
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic        m_axis_tuser,  // [0] unit_start
	output logic        m_axis_tlast
);

	lpsc_pkg::q_port_t push;
	lpsc_pkg::q_port_t head;
	logic              q_full;
	logic              pop;

	lpsc_front #(
		.SAMPLE_LEN_BITS(SAMPLE_LEN_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (q_full),
		.push         (push)
	);

	lpsc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.full  (q_full),
		.head  (head)
	);

	lpsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

/* rtl/lpsc_checker.sv */
// ----------------------------------------------------------------------------
// lpsc_checker
// Port-level checks for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
module lpsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// first start-code byte is zero and never closes the run
	a_unit_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00 && !m_axis_tlast)
		else $error("bad first start-code byte");

	// queue can only fill while output holds a beat
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with output empty");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind length_prefix_to_start_code lpsc_checker u_lpsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
